// File: hdl/waveform_min_max_decimator_unit_macros.svh
// assertion helpers shared by the checker files
`ifndef WAVEFORM_MIN_MAX_DECIMATOR_UNIT_MACROS_SVH
`define WAVEFORM_MIN_MAX_DECIMATOR_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define WMMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decimator port check failed");

// next-cycle implication, off while in reset
`define WMMD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decimator port check failed");

// next-cycle implication that also watches the reset itself
`define WMMD_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("decimator reset check failed");

`endif

// File: hdl/wmmd_pkg.sv
`timescale 1ns / 1ps

package wmmd_pkg;

  // default sample storage width
  localparam int SAMPLE_WIDTH_DEF = 16;

  // plot width bound, saturates the configured width
  localparam int MAX_PLOT_WIDTH = 4096;
  localparam logic [11:0] W_CAP = (MAX_PLOT_WIDTH - 1 > 4095) ? 12'd4095 :
                                  12'(MAX_PLOT_WIDTH - 1);

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // state widths
  localparam int ACC_W = 36;
  localparam int POS_W = 24;
  localparam int COL_W = 12;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_BITS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SCALE     = 3'd5;

  // point kinds
  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_MAX    = 2'd1;
  localparam logic [1:0] KIND_MIN    = 2'd2;

  typedef struct packed {
    logic [4:0]  adc_bits;
    logic [23:0] visible_count;
    logic [11:0] plot_width;
    logic [11:0] plot_height;
    logic [15:0] window_low;
    logic [31:0] row_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    adc_bits:      5'd12,
    visible_count: 24'd1024,
    plot_width:    12'd1024,
    plot_height:   12'd512,
    window_low:    16'd0,
    row_scale:     32'd65536
  };

endpackage

// File: hdl/wmmd_front.sv
`timescale 1ns / 1ps

module wmmd_front import wmmd_pkg::*; #(
  parameter int SW    = SAMPLE_WIDTH_DEF,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [15:0]   in_tdata,   // sample
  input  logic [0:0]    in_tuser,   // frame_start
  input  logic [4:0]    adc_bits,
  input  logic          hold,
  input  logic          pop,
  output logic          q_valid,
  output logic [SW-1:0] q_code,
  output logic          q_frame
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;
  localparam logic [4:0] SW_BITS = 5'(SW);

  logic [SW-1:0]    code_mem_r [DEPTH];
  logic             frame_mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic [4:0]  bits;
  logic [16:0] mask_wide;
  logic [15:0] masked;
  logic        full, push;

  // sample mask from the valid bit count, saturated to the storage width
  assign bits      = (adc_bits > SW_BITS) ? SW_BITS : adc_bits;
  assign mask_wide = (17'd1 << bits) - 17'd1;
  assign masked    = in_tdata & mask_wide[15:0];

  assign full      = (count_r == CNT_W'(DEPTH));
  assign in_tready = !hold && !full;
  assign push      = in_tvalid && in_tready;

  assign q_valid = (count_r != '0);
  assign q_code  = code_mem_r[rd_ptr_r];
  assign q_frame = frame_mem_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      code_mem_r[wr_ptr_r]  <= masked[SW-1:0];
      frame_mem_r[wr_ptr_r] <= in_tuser[0];
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= PTR_W'(wr_ptr_r + 1'b1);
      if (pop)  rd_ptr_r <= PTR_W'(rd_ptr_r + 1'b1);
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// File: hdl/wmmd_div.sv
`timescale 1ns / 1ps

module wmmd_div import wmmd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] dividend,
  input  logic [POS_W-1:0] divisor,
  output logic             done,
  output logic [ACC_W-1:0] quotient,
  output logic [POS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(ACC_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ACC_W - 1);

  logic [ACC_W-1:0] qr_r;
  logic [POS_W-1:0] rem_r, div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;

  logic [POS_W:0] shifted, diff;
  logic           ge;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign shifted = {rem_r, qr_r[ACC_W-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign ge      = (shifted >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (start) begin
      qr_r  <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      qr_r  <= {qr_r[ACC_W-2:0], ge};
      rem_r <= ge ? diff[POS_W-1:0] : shifted[POS_W-1:0];
    end
  end

  // step count and completion flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done      = done_r;
  assign quotient  = qr_r;
  assign remainder = rem_r;

endmodule

// File: hdl/wmmd_back.sv
`timescale 1ns / 1ps

module wmmd_back import wmmd_pkg::*; #(
  parameter int SW = SAMPLE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             cfg_wr,
  input  logic             q_valid,
  input  logic [SW-1:0]    q_code,
  input  logic             q_frame,
  output logic             q_pop,
  output logic             busy,
  output logic             ev_valid,
  output logic             ev_two,
  output logic [COL_W-1:0] ev_col,
  output logic [SW-1:0]    ev_code_a,
  output logic [SW-1:0]    ev_code_b,
  input  logic             ev_ready
);

  // recompute sequencer codes
  localparam logic [1:0] SEQ_MUL  = 2'd0;
  localparam logic [1:0] SEQ_DIV1 = 2'd1;
  localparam logic [1:0] SEQ_DIV2 = 2'd2;
  localparam logic [1:0] SEQ_RUN  = 2'd3;

  logic [1:0] seq_r, seq_nxt;

  // frame state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [COL_W-1:0] col_idx_r, col_idx_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [SW-1:0]    min_r, min_nxt, max_r, max_nxt;
  logic             open_r, open_nxt;

  // derived state: acc / (vis-1) and width / (vis-1) as quotient and remainder, pos * width
  logic [COL_W-1:0] quo_r, quo_nxt, qstep_r, qstep_nxt;
  logic [POS_W-1:0] rem_r, rem_nxt, rstep_r, rstep_nxt;
  logic [ACC_W-1:0] prod_r, prod_nxt;

  // event register
  logic             ev_valid_r;
  logic             ev_two_r;
  logic [COL_W-1:0] ev_col_r;
  logic [SW-1:0]    ev_code_a_r, ev_code_b_r;

  logic             emit_c, two_c;
  logic [COL_W-1:0] col_c;
  logic [SW-1:0]    code_a_c, code_b_c;

  logic             slot_free;
  logic [POS_W-1:0] vis_eff, dvs;
  logic [COL_W-1:0] weff;
  logic             single_mode;

  logic [POS_W-1:0] pos_c, rem_c;
  logic [COL_W-1:0] col_idx_c, quo_c;
  logic [ACC_W-1:0] acc_c, prod_c;
  logic             open_c;

  logic [POS_W:0]   rem_sum;
  logic             rem_wrap;
  logic [ACC_W:0]   close_lhs, close_rhs;
  logic             close;
  logic [SW-1:0]    min_new, max_new;

  logic             div_start, div_done;
  logic [ACC_W-1:0] div_dividend, div_quo;
  logic [POS_W-1:0] div_rem;

  // effective register values
  assign vis_eff     = (cfg.visible_count == '0) ? POS_W'(1) : cfg.visible_count;
  assign weff        = (cfg.plot_width == '0) ? COL_W'(1) :
                       (cfg.plot_width > W_CAP) ? W_CAP : cfg.plot_width;
  assign dvs         = vis_eff - 1'b1;
  assign single_mode = (vis_eff <= POS_W'(weff));

  // frame start clears the counters before the sample is handled
  assign pos_c     = q_frame ? '0 : pos_r;
  assign col_idx_c = q_frame ? '0 : col_idx_r;
  assign acc_c     = q_frame ? '0 : acc_r;
  assign open_c    = q_frame ? 1'b0 : open_r;
  assign quo_c     = q_frame ? '0 : quo_r;
  assign rem_c     = q_frame ? '0 : rem_r;
  assign prod_c    = q_frame ? '0 : prod_r;

  // single mode: step the quotient by width / (vis-1) with one carry
  assign rem_sum  = {1'b0, rem_c} + {1'b0, rstep_r};
  assign rem_wrap = (rem_sum >= {1'b0, dvs});

  // binned mode: column closes when acc + vis < (pos + 2) * width
  assign close_lhs = {1'b0, acc_c} + (ACC_W + 1)'(vis_eff);
  assign close_rhs = {1'b0, prod_c} + (ACC_W + 1)'({weff, 1'b0});
  assign close     = (close_lhs < close_rhs);

  // running column extremes
  assign min_new = (!open_c || q_code < min_r) ? q_code : min_r;
  assign max_new = (!open_c || q_code > max_r) ? q_code : max_r;

  assign slot_free = !ev_valid_r || ev_ready;
  assign busy      = (seq_r != SEQ_RUN);
  assign q_pop     = (seq_r == SEQ_RUN) && q_valid && slot_free;

  // shared divider for the recompute pass
  assign div_start    = (seq_r == SEQ_MUL) || ((seq_r == SEQ_DIV1) && div_done);
  assign div_dividend = (seq_r == SEQ_MUL) ? acc_r : ACC_W'(weff);

  wmmd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    seq_nxt     = seq_r;
    pos_nxt     = pos_r;
    col_idx_nxt = col_idx_r;
    acc_nxt     = acc_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    open_nxt    = open_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    prod_nxt    = prod_r;
    qstep_nxt   = qstep_r;
    rstep_nxt   = rstep_r;
    emit_c      = 1'b0;
    two_c       = 1'b0;
    col_c       = '0;
    code_a_c    = q_code;
    code_b_c    = q_code;

    unique case (seq_r)
      SEQ_MUL: begin
        prod_nxt = ACC_W'(pos_r) * ACC_W'(weff);
        seq_nxt  = SEQ_DIV1;
      end
      SEQ_DIV1: begin
        if (div_done) begin
          quo_nxt = div_quo[COL_W-1:0];
          rem_nxt = div_rem;
          seq_nxt = SEQ_DIV2;
        end
      end
      SEQ_DIV2: begin
        if (div_done) begin
          qstep_nxt = div_quo[COL_W-1:0];
          rstep_nxt = div_rem;
          seq_nxt   = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (q_pop) begin
          pos_nxt     = pos_c;
          col_idx_nxt = col_idx_c;
          acc_nxt     = acc_c;
          open_nxt    = open_c;
          quo_nxt     = quo_c;
          rem_nxt     = rem_c;
          prod_nxt    = prod_c;
          if (pos_c < vis_eff) begin
            if (single_mode) begin
              // one point per sample
              emit_c   = 1'b1;
              col_c    = (vis_eff > POS_W'(1)) ? quo_c : '0;
              acc_nxt  = acc_c + ACC_W'(weff);
              pos_nxt  = pos_c + 1'b1;
              prod_nxt = prod_c + ACC_W'(weff);
              quo_nxt  = quo_c + qstep_r + COL_W'(rem_wrap);
              rem_nxt  = rem_wrap ? POS_W'(rem_sum - {1'b0, dvs}) : rem_sum[POS_W-1:0];
            end else if (col_idx_c < weff) begin
              // binned column
              min_nxt  = min_new;
              max_nxt  = max_new;
              open_nxt = 1'b1;
              pos_nxt  = pos_c + 1'b1;
              prod_nxt = prod_c + ACC_W'(weff);
              if (close) begin
                emit_c      = 1'b1;
                two_c       = 1'b1;
                col_c       = col_idx_c;
                code_a_c    = max_new;
                code_b_c    = min_new;
                col_idx_nxt = col_idx_c + 1'b1;
                acc_nxt     = acc_c + ACC_W'(vis_eff);
                open_nxt    = 1'b0;
              end
            end
          end
        end
      end
      default: seq_nxt = SEQ_MUL;
    endcase

    // a register write invalidates the derived state
    if (cfg_wr) seq_nxt = SEQ_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= SEQ_MUL;
      pos_r     <= '0;
      col_idx_r <= '0;
      acc_r     <= '0;
      min_r     <= '0;
      max_r     <= '0;
      open_r    <= 1'b0;
    end else begin
      seq_r     <= seq_nxt;
      pos_r     <= pos_nxt;
      col_idx_r <= col_idx_nxt;
      acc_r     <= acc_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      open_r    <= open_nxt;
    end
  end

  // derived state is rebuilt by the sequencer after reset
  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    prod_r  <= prod_nxt;
    qstep_r <= qstep_nxt;
    rstep_r <= rstep_nxt;
  end

  // event register towards the row mapper
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else if (slot_free) begin
      ev_valid_r <= emit_c;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit_c) begin
      ev_two_r    <= two_c;
      ev_col_r    <= col_c;
      ev_code_a_r <= code_a_c;
      ev_code_b_r <= code_b_c;
    end
  end

  assign ev_valid  = ev_valid_r;
  assign ev_two    = ev_two_r;
  assign ev_col    = ev_col_r;
  assign ev_code_a = ev_code_a_r;
  assign ev_code_b = ev_code_b_r;

endmodule

// File: hdl/wmmd_emit.sv
`timescale 1ns / 1ps

module wmmd_emit import wmmd_pkg::*; #(
  parameter int SW = SAMPLE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             ev_valid,
  input  logic             ev_two,
  input  logic [COL_W-1:0] ev_col,
  input  logic [SW-1:0]    ev_code_a,
  input  logic [SW-1:0]    ev_code_b,
  output logic             ev_ready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata,  // pixel_column, pixel_row
  output logic [1:0]       out_tuser,  // point_kind
  output logic             out_tlast   // run_last
);

  localparam int PROD_W = SW + 32;
  localparam int ROW_W  = SW + 16;

  // multiply stage
  logic             m_v_r, m_two_r;
  logic [COL_W-1:0] m_col_r;
  logic [PROD_W-1:0] m_prod_a_r, m_prod_b_r;

  // output stage
  logic             o_v_r, o_two_r, o_phase_r;
  logic [COL_W-1:0] o_col_r;
  logic [11:0]      o_row_a_r, o_row_b_r;

  logic [15:0]       code_a16, code_b16, diff_a16, diff_b16;
  logic [SW-1:0]     diff_a, diff_b;
  logic [PROD_W-1:0] prod_a, prod_b;
  logic [ROW_W-1:0]  row_a_full, row_b_full, h_ext;
  logic [11:0]       row_a, row_b;
  logic              o_last_word, o_free, m_free;

  // codes at or below the window floor map to row zero
  assign code_a16 = 16'(ev_code_a);
  assign code_b16 = 16'(ev_code_b);
  assign diff_a16 = code_a16 - cfg.window_low;
  assign diff_b16 = code_b16 - cfg.window_low;
  assign diff_a   = (code_a16 > cfg.window_low) ? diff_a16[SW-1:0] : '0;
  assign diff_b   = (code_b16 > cfg.window_low) ? diff_b16[SW-1:0] : '0;
  assign prod_a   = PROD_W'(diff_a) * PROD_W'(cfg.row_scale);
  assign prod_b   = PROD_W'(diff_b) * PROD_W'(cfg.row_scale);

  // drop the fraction and clamp to the plot height
  assign h_ext      = ROW_W'(cfg.plot_height);
  assign row_a_full = m_prod_a_r[PROD_W-1:16];
  assign row_b_full = m_prod_b_r[PROD_W-1:16];
  assign row_a      = (row_a_full > h_ext) ? cfg.plot_height : row_a_full[11:0];
  assign row_b      = (row_b_full > h_ext) ? cfg.plot_height : row_b_full[11:0];

  // stage handshakes
  assign o_last_word = !o_two_r || o_phase_r;
  assign o_free      = !o_v_r || (out_tready && o_last_word);
  assign m_free      = !m_v_r || o_free;
  assign ev_ready    = m_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r     <= 1'b0;
      o_v_r     <= 1'b0;
      o_phase_r <= 1'b0;
    end else begin
      if (m_free) m_v_r <= ev_valid;
      if (o_free) begin
        o_v_r     <= m_v_r;
        o_phase_r <= 1'b0;
      end else if (out_tready) begin
        // max word taken, the min word follows
        o_phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_free && ev_valid) begin
      m_two_r    <= ev_two;
      m_col_r    <= ev_col;
      m_prod_a_r <= prod_a;
      m_prod_b_r <= prod_b;
    end
    if (o_free && m_v_r) begin
      o_two_r   <= m_two_r;
      o_col_r   <= m_col_r;
      o_row_a_r <= row_a;
      o_row_b_r <= row_b;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {(o_phase_r ? o_row_b_r : o_row_a_r), o_col_r};
  assign out_tuser  = !o_two_r ? KIND_SINGLE : (o_phase_r ? KIND_MIN : KIND_MAX);
  assign out_tlast  = o_last_word;

endmodule

// File: hdl/waveform_min_max_decimator_unit.sv
`timescale 1ns / 1ps
// a sample's points pass the queue, event register, multiply stage and output stage
// throughput: one sample word per cycle unless held by a full queue or a recompute;
//   two-word closing columns on consecutive samples let the output port set the pace
// reset: synchronous, active low; registers take their reset values and counters clear
// after reset and after every register write a recompute pass (one multiply,
//   two 36-step divisions on the shared serial divider) holds in_tready low

module waveform_min_max_decimator_unit import wmmd_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // sample
  input  logic [0:0]           in_tuser,   // frame_start
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // pixel_column, pixel_row
  output logic [1:0]           out_tuser,  // point_kind
  output logic                 out_tlast,  // run_last
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t cfg_r;
  logic cfg_wr;

  logic                    hold, pop, q_valid, q_frame;
  logic [SAMPLE_WIDTH-1:0] q_code;

  logic                    ev_valid, ev_two, ev_ready;
  logic [COL_W-1:0]        ev_col;
  logic [SAMPLE_WIDTH-1:0] ev_code_a, ev_code_b;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_ADC_BITS:      cfg_r.adc_bits      <= cfg_data[4:0];
        REG_VISIBLE_COUNT: cfg_r.visible_count <= cfg_data[23:0];
        REG_PLOT_WIDTH:    cfg_r.plot_width    <= cfg_data[11:0];
        REG_PLOT_HEIGHT:   cfg_r.plot_height   <= cfg_data[11:0];
        REG_WINDOW_LOW:    cfg_r.window_low    <= cfg_data[15:0];
        REG_ROW_SCALE:     cfg_r.row_scale     <= cfg_data;
        default: ;
      endcase
    end
  end

  wmmd_front #(
    .SW    (SAMPLE_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .adc_bits  (cfg_r.adc_bits),
    .hold      (hold),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_code    (q_code),
    .q_frame   (q_frame)
  );

  wmmd_back #(
    .SW (SAMPLE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cfg_wr    (cfg_wr),
    .q_valid   (q_valid),
    .q_code    (q_code),
    .q_frame   (q_frame),
    .q_pop     (pop),
    .busy      (hold),
    .ev_valid  (ev_valid),
    .ev_two    (ev_two),
    .ev_col    (ev_col),
    .ev_code_a (ev_code_a),
    .ev_code_b (ev_code_b),
    .ev_ready  (ev_ready)
  );

  wmmd_emit #(
    .SW (SAMPLE_WIDTH)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .ev_valid   (ev_valid),
    .ev_two     (ev_two),
    .ev_col     (ev_col),
    .ev_code_a  (ev_code_a),
    .ev_code_b  (ev_code_b),
    .ev_ready   (ev_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hdl/wmmd_checker.sv
`timescale 1ns / 1ps
`include "waveform_min_max_decimator_unit_macros.svh"

module wmmd_checker import wmmd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a stalled output word holds
  `WMMD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a column maximum is never the last word of its sample
  `WMMD_ASSERT_IMP(a_max_not_last, out_tvalid && out_tuser == KIND_MAX, !out_tlast)

  // the column minimum follows its maximum at once
  `WMMD_ASSERT_NXT(a_min_follows, out_tvalid && out_tready && out_tuser == KIND_MAX, out_tvalid && out_tuser == KIND_MIN)

  // a register write starts the recompute pass, no sample word is taken
  `WMMD_ASSERT_NXT(a_cfg_holds_input, cfg_valid && cfg_ready, !in_tready)

  // the recompute pass also follows reset
  `WMMD_ASSERT_RST(a_reset_holds_input, !rst_n, !in_tready)

endmodule

bind waveform_min_max_decimator_unit wmmd_checker u_wmmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

// File: bench/waveform_min_max_decimator_unit_test.sv
`timescale 1ns / 1ps

module waveform_min_max_decimator_unit_test;
  import wmmd_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1900;
  localparam int FRAME_CAP    = 150;
  localparam int REPORT_LIMIT = 10;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // one plotted point as it leaves the block
  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic [1:0]  kind;
    logic        last;
  } point_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_EVERY_THIRD, RX_SPARSE} rx_pattern_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;   // sample
  logic [0:0]           in_tuser   = '0;   // frame_start
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;         // pixel_column, pixel_row
  logic [1:0]           out_tuser;         // point_kind
  logic                 out_tlast;         // run_last
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [31:0]          cfg_data   = '0;

  waveform_min_max_decimator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // shadow registers and decimator state
  cfg_t        live_cfg;
  logic [23:0] frame_pos   = '0;
  logic [11:0] column_at   = '0;
  logic [35:0] bound_acc   = '0;
  logic [15:0] col_lo      = '0;
  logic [15:0] col_hi      = '0;
  logic        col_busy    = 1'b0;

  point_t      pending_points[$];
  point_t      seen_point;
  point_t      want_point;
  int          error_count   = 0;
  int          counted_items = 0;
  int          cycle_count   = 0;
  int          burst_left    = 0;
  rx_pattern_t rx_pattern    = RX_OPEN;
  int          rx_left       = 0;
  int          rx_tick       = 0;

  // row of a code: offset from the window bottom, scaled in q16, clamped to height
  function automatic logic [11:0] row_for_code(logic [15:0] code);
    logic [63:0] scaled;
    if (code <= live_cfg.window_low) return 12'd0;
    scaled = (64'(code - live_cfg.window_low) * 64'(live_cfg.row_scale)) >> 16;
    if (scaled > 64'(live_cfg.plot_height)) scaled = 64'(live_cfg.plot_height);
    return scaled[11:0];
  endfunction

  function automatic void expect_point(logic [11:0] col, logic [11:0] row, logic [1:0] kind,
                                       logic last);
    pending_points.insert(pending_points.size(), {col, row, kind, last});
  endfunction

  // advance the decimator by one sample; returns 1 when the sample took part in the frame
  function automatic bit decimate_sample(logic [15:0] sample, logic frame_start);
    logic [4:0]  bits;
    logic [15:0] mask;
    logic [15:0] code;
    logic [23:0] vis;
    logic [11:0] w;
    logic [11:0] col;
    logic [63:0] quot;
    bits = (live_cfg.adc_bits > 5'd16) ? 5'd16 : live_cfg.adc_bits;
    mask = 16'((17'd1 << bits) - 17'd1);
    code = sample & mask;
    vis  = (live_cfg.visible_count == '0) ? 24'd1 : live_cfg.visible_count;
    w    = (live_cfg.plot_width == '0) ? 12'd1 : live_cfg.plot_width;
    if (w > W_CAP) w = W_CAP;
    if (frame_start) begin
      frame_pos = '0;
      column_at = '0;
      bound_acc = '0;
      col_busy  = 1'b0;
    end
    if (frame_pos >= vis) return 1'b0;
    // one point per sample, column spread over the width
    if (vis <= 24'(w)) begin
      col = 12'd0;
      if (vis > 24'd1) begin
        quot = 64'(bound_acc) / 64'(vis - 24'd1);
        col  = quot[11:0];
      end
      bound_acc = bound_acc + 36'(w);
      frame_pos = frame_pos + 24'd1;
      expect_point(col, row_for_code(code), KIND_SINGLE, 1'b1);
      return 1'b1;
    end
    // binned: every column already closed
    if (column_at >= w) return 1'b0;
    if (!col_busy) begin
      col_lo   = code;
      col_hi   = code;
      col_busy = 1'b1;
    end else begin
      if (code < col_lo) col_lo = code;
      if (code > col_hi) col_hi = code;
    end
    frame_pos = frame_pos + 24'd1;
    quot = (64'(bound_acc) + 64'(vis)) / 64'(w);
    if (quot <= 64'(frame_pos)) begin
      expect_point(column_at, row_for_code(col_hi), KIND_MAX, 1'b0);
      expect_point(column_at, row_for_code(col_lo), KIND_MIN, 1'b1);
      column_at = column_at + 12'd1;
      bound_acc = bound_acc + 36'(vis);
      col_busy  = 1'b0;
    end
    return 1'b1;
  endfunction

  // sample word, sometimes an extreme
  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // register set for one phase, mostly small frames
  function automatic cfg_t random_settings();
    cfg_t            s;
    int              bits;
    longint unsigned span;
    int              pick;
    s = CFG_RESET;
    s.adc_bits = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) :
                                               5'($urandom_range(8, 16));
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      s.plot_width    = ($urandom_range(0, 5) == 0) ? 12'd4095 : 12'($urandom_range(1, 64));
      s.visible_count = 24'($urandom_range(1, (s.plot_width < 64) ? s.plot_width : 64));
    end else if (pick <= 8) begin
      s.plot_width    = 12'($urandom_range(1, 32));
      s.visible_count = 24'($urandom_range(s.plot_width + 1, 96));
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          s.visible_count = 24'hFFFFFF;
          s.plot_width    = 12'($urandom_range(1, 4095));
        end
        1: begin
          s.visible_count = 24'd0;
          s.plot_width    = 12'd0;
        end
        2: begin
          s.visible_count = 24'($urandom_range(4096, 4300));
          s.plot_width    = 12'd4095;
        end
        default: begin
          s.visible_count = 24'd4095;
          s.plot_width    = 12'd4095;
        end
      endcase
    end
    case ($urandom_range(0, 7))
      0:       s.plot_height = 12'd1;
      1:       s.plot_height = 12'd4095;
      2:       s.plot_height = 12'($urandom_range(0, 3));
      default: s.plot_height = 12'($urandom_range(1, 4095));
    endcase
    bits = (s.adc_bits > 16) ? 16 : int'(s.adc_bits);
    s.window_low = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, (1 << bits) - 1));
    span = (64'd1 << bits) - 64'(s.window_low);
    if (span == 0) span = 1;
    case ($urandom_range(0, 5))
      0:       s.row_scale = 32'd0;
      1:       s.row_scale = 32'hFFFFFFFF;
      2:       s.row_scale = 32'($urandom);
      default: s.row_scale = 32'((64'(s.plot_height) << 16) / span);
    endcase
    return s;
  endfunction

  // one sample word, with burst and gap pacing in front
  task automatic send_sample(logic [15:0] sample, logic frame_start);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    in_tuser  <= frame_start;
    do @(posedge clk); while (!in_tready);
    if (decimate_sample(sample, frame_start)) counted_items++;
  endtask

  // stop sending and wait for every expected point
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  // block idle: nothing pending and the pipeline flushed of silent samples
  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_ADC_BITS:      live_cfg.adc_bits      = value[4:0];
      REG_VISIBLE_COUNT: live_cfg.visible_count = value[23:0];
      REG_PLOT_WIDTH:    live_cfg.plot_width    = value[11:0];
      REG_PLOT_HEIGHT:   live_cfg.plot_height   = value[11:0];
      REG_WINDOW_LOW:    live_cfg.window_low    = value[15:0];
      REG_ROW_SCALE:     live_cfg.row_scale     = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(REG_ADC_BITS, 32'(s.adc_bits));
    write_reg(REG_VISIBLE_COUNT, 32'(s.visible_count));
    write_reg(REG_PLOT_WIDTH, 32'(s.plot_width));
    write_reg(REG_PLOT_HEIGHT, 32'(s.plot_height));
    write_reg(REG_WINDOW_LOW, 32'(s.window_low));
    write_reg(REG_ROW_SCALE, s.row_scale);
  endtask

  // reset settings: single mode, 12 bit mask, rows clamped at 512
  task automatic test_default_frame();
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0FFF, 1'b0);
    send_sample(16'h1000, 1'b0);
    send_sample(16'h8001, 1'b0);
  endtask

  // zero and saturated register values, window edges, samples past the frame
  task automatic test_register_extremes();
    settle();
    write_reg(REG_ADC_BITS, 32'd0);
    write_reg(REG_VISIBLE_COUNT, 32'd1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h1234, 1'b0);
    settle();
    write_reg(REG_ADC_BITS, 32'd31);
    write_reg(REG_VISIBLE_COUNT, 32'd0);
    write_reg(REG_PLOT_WIDTH, 32'd0);
    write_reg(REG_UNUSED, $urandom);
    send_sample(16'hFFFF, 1'b1);
    settle();
    write_reg(REG_WINDOW_LOW, 32'h8000);
    write_reg(REG_PLOT_HEIGHT, 32'd4095);
    write_reg(REG_ROW_SCALE, 32'hFFFFFFFF);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'hFFFF, 1'b1);
  endtask

  // few samples over the widest plot: columns at both ends
  task automatic test_wide_single();
    settle();
    write_reg(REG_PLOT_WIDTH, 32'd4095);
    write_reg(REG_VISIBLE_COUNT, 32'd3);
    write_reg(REG_WINDOW_LOW, 32'd0);
    write_reg(REG_ROW_SCALE, 32'd65536);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0800, 1'b0);
    send_sample(16'h5555, 1'b0);
  endtask

  // six samples into four columns, max then min per column
  task automatic test_binned_columns();
    settle();
    write_reg(REG_ADC_BITS, 32'd16);
    write_reg(REG_VISIBLE_COUNT, 32'd6);
    write_reg(REG_PLOT_WIDTH, 32'd4);
    send_sample(16'h0100, 1'b1);
    send_sample(16'h0F00, 1'b0);
    send_sample(16'h0080, 1'b0);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hFFFF, 1'b0);
  endtask

  // width narrowed under an open frame, then restored
  task automatic test_midframe_change();
    settle();
    send_sample(16'h0300, 1'b1);
    send_sample(16'h0200, 1'b0);
    send_sample(16'h0400, 1'b0);
    settle();
    write_reg(REG_PLOT_WIDTH, 32'd2);
    send_sample(16'h0500, 1'b0);
    settle();
    write_reg(REG_PLOT_WIDTH, 32'd4);
    send_sample(16'h0600, 1'b0);
    send_sample(16'h0700, 1'b1);
  endtask

  // sender holds off mid-frame until the output has caught up
  task automatic test_drain_pause();
    cfg_t s;
    s = CFG_RESET;
    s.visible_count = 24'd40;
    s.plot_width    = 12'd8;
    settle();
    apply_settings(s);
    send_sample(random_word(), 1'b1);
    repeat (19) send_sample(random_word(), 1'b0);
    wait_drained();
    repeat (20) send_sample(random_word(), 1'b0);
  endtask

  // random settings, mostly whole frames, some cut short, restarted or without a start
  task automatic test_random_frames();
    cfg_t s;
    int   target;
    int   vis_eff;
    int   len;
    int   extra;
    int   shape;
    target = counted_items + RANDOM_ITEMS;
    while (counted_items < target) begin
      settle();
      s = random_settings();
      apply_settings(s);
      vis_eff = (s.visible_count == '0) ? 1 : int'(s.visible_count);
      repeat ($urandom_range(1, 5)) begin
        len   = (vis_eff > FRAME_CAP) ? FRAME_CAP : vis_eff;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
          repeat ($urandom_range(1, 8)) send_sample(random_word(), 1'b0);
        end else begin
          if (shape == 1) len = $urandom_range(1, len);
          extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
          send_sample(random_word(), 1'b1);
          repeat (len - 1 + extra) send_sample(random_word(), 1'b0);
        end
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
    end
  endtask

  // receiver ready pattern, picked anew at random when the current one runs out
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_left    = $urandom_range(20, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_pattern)
      RX_OPEN:        out_tready <= 1'b1;
      RX_RANDOM:      out_tready <= ($urandom_range(0, 9) < 7);
      RX_EVERY_THIRD: out_tready <= (rx_tick % 3 == 0);
      default:        out_tready <= (rx_tick % 8 == 0);
    endcase
  end

  // compare each output word with the oldest expected point
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_point = {out_tdata[11:0], out_tdata[23:12], out_tuser, out_tlast};
      if (pending_points.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected point: col %0d row %0d kind %0d last %0d", seen_point.column,
                   seen_point.row, seen_point.kind, seen_point.last);
      end else begin
        want_point = pending_points.pop_front();
        if (seen_point.column !== want_point.column || seen_point.row !== want_point.row ||
            seen_point.kind !== want_point.kind || seen_point.last !== want_point.last) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                     want_point.column, want_point.row, want_point.kind, want_point.last,
                     seen_point.column, seen_point.row, seen_point.kind, seen_point.last);
        end
      end
    end
  end

  // overall time limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("waveform_min_max_decimator_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    live_cfg = CFG_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_frame();
    test_register_extremes();
    test_wide_single();
    test_binned_columns();
    test_midframe_change();
    test_drain_pause();
    test_random_frames();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_points.size() == 0) begin
      $display("waveform_min_max_decimator_unit_test OK");
    end else begin
      $display("waveform_min_max_decimator_unit_test NOT OK");
    end
    $finish;
  end

endmodule
